@@ src/cfp_pkg.sv @@
package cfp_pkg;

    // Result codes carried on the result channel
    typedef enum logic [2:0] {
        RC_RTM       = 3'd0,
        RC_RFL       = 3'd1,
        RC_RID       = 3'd2,
        RC_RHL       = 3'd3,
        RC_RPR       = 3'd4,
        RC_UNKNOWN   = 3'd5,
        RC_NONLETTER = 3'd6,
        RC_TOOLONG   = 3'd7
    } t_result;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_MAX_LENGTH = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    localparam logic [7:0] START_BYTE_RST = 8'h3A;
    localparam logic [7:0] END_BYTE_RST   = 8'h3B;
    localparam logic [7:0] MAX_LENGTH_RST = 8'd104;

    // Command letters
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_I = 8'h49;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_P = 8'h50;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

endpackage

@@ src/command_frame_parser_top.sv @@
// Command frame parser.
// Input channel: one received byte per request on i_rx_byte, handshake
// i_rx_valid / o_rx_ready. Result channel: result code and the three kept
// command bytes, handshake o_res_valid / i_res_ready. A result appears only
// for a byte that ends a frame or makes it too long; other bytes give none.
// Configuration: write i_cfg_data to register i_cfg_index (0 start byte,
// 1 end byte, 2 max length) on any edge with i_cfg_we high, while idle.
// A result is valid in the cycle after its byte is accepted.
// One byte per cycle while o_rx_ready is high; the frame state is updated in the cycle
// a byte is accepted and the result lands in a single output register.
// When the receiver stalls, the result register holds and o_rx_ready drops
// only while a result waits and i_res_ready is low; a byte that gives no
// result is never blocked by anything but that waiting result.
// Reset (synchronous, active low): closes any frame, clears the length
// count and command bytes, restores the register defaults (':' ';' 104)
// and empties the result register.
module command_frame_parser_top
    import cfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [2:0] o_result_code,
    output logic [7:0] o_cmd_first,
    output logic [7:0] o_cmd_second,
    output logic [7:0] o_cmd_third
);

    logic [7:0] r_start_byte, r_end_byte, r_max_length;
    logic       r_in_frame, n_in_frame;
    logic [7:0] r_count, n_count;
    logic [7:0] r_cmd [3];
    logic [7:0] n_cmd [3];
    logic       r_res_valid;
    t_result    r_result, n_result;
    logic [7:0] r_echo [3];
    logic       n_emit;
    logic       accept;
    logic       open_now;
    logic [8:0] count_inc;
    logic       all_letters;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    assign accept     = i_rx_valid && o_rx_ready;
    assign o_rx_ready = !r_res_valid || i_res_ready;

    // Next frame state and result for the byte at the input
    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_cmd      = r_cmd;
        n_emit     = 1'b0;
        n_result   = RC_UNKNOWN;
        open_now   = r_in_frame || (i_rx_byte == r_start_byte);
        count_inc  = 9'd0;
        all_letters = 1'b0;
        if (open_now) begin
            if (i_rx_byte == r_start_byte) begin
                n_count = 8'd0;
            end
            // keep command bytes at positions 1 to 3
            case (n_count)
                8'd1:    n_cmd[0] = i_rx_byte;
                8'd2:    n_cmd[1] = i_rx_byte;
                8'd3:    n_cmd[2] = i_rx_byte;
                default: ;
            endcase
            count_inc = {1'b0, n_count} + 9'd1;
            all_letters = is_letter(n_cmd[0]) && is_letter(n_cmd[1]) &&
                          is_letter(n_cmd[2]);
            n_in_frame = 1'b1;
            if (count_inc > {1'b0, r_max_length}) begin
                n_in_frame = 1'b0;
                n_count    = 8'd0;
                n_emit     = 1'b1;
                n_result   = RC_TOOLONG;
            end else if (i_rx_byte == r_end_byte) begin
                n_in_frame = 1'b0;
                n_count    = 8'd0;
                n_emit     = 1'b1;
                if (!all_letters) begin
                    n_result = RC_NONLETTER;
                end else if (n_cmd[0] != CH_R) begin
                    n_result = RC_UNKNOWN;
                end else if (n_cmd[1] == CH_T && n_cmd[2] == CH_M) begin
                    n_result = RC_RTM;
                end else if (n_cmd[1] == CH_F && n_cmd[2] == CH_L) begin
                    n_result = RC_RFL;
                end else if (n_cmd[1] == CH_I && n_cmd[2] == CH_D) begin
                    n_result = RC_RID;
                end else if (n_cmd[1] == CH_H && n_cmd[2] == CH_L) begin
                    n_result = RC_RHL;
                end else if (n_cmd[1] == CH_P && n_cmd[2] == CH_R) begin
                    n_result = RC_RPR;
                end
            end else begin
                n_count = count_inc[7:0];
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_end_byte   <= END_BYTE_RST;
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_END_BYTE:   r_end_byte   <= i_cfg_data;
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame state: advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= 8'd0;
            r_cmd[0]   <= 8'd0;
            r_cmd[1]   <= 8'd0;
            r_cmd[2]   <= 8'd0;
        end else if (accept) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_cmd      <= n_cmd;
        end
    end

    // Result register: load on a result, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (accept && n_emit) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_result <= n_result;
            r_echo   <= n_cmd;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_result_code = r_result;
    assign o_cmd_first   = r_echo[0];
    assign o_cmd_second  = r_echo[1];
    assign o_cmd_third   = r_echo[2];

endmodule

@@ src/cfp_checker.sv @@
module cfp_checker
    import cfp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_ready,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic [2:0] o_result_code,
    input logic [7:0] o_cmd_first,
    input logic [7:0] o_cmd_second,
    input logic [7:0] o_cmd_third
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_result_code) &&
        $stable(o_cmd_first) && $stable(o_cmd_second) && $stable(o_cmd_third))
        else $error("stalled result changed");

    // A new result follows an accepted request
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(i_rx_valid && o_rx_ready))
        else $error("result without an accepted request");

    // Empty result register never blocks input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> o_rx_ready)
        else $error("input blocked with no result pending");

    // Known commands all start with R
    a_known_r: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_result_code == RC_RTM || o_result_code == RC_RFL ||
        o_result_code == RC_RID || o_result_code == RC_RHL ||
        o_result_code == RC_RPR) |-> o_cmd_first == CH_R)
        else $error("known command code without leading R");

endmodule

bind command_frame_parser_top cfp_checker u_cfp_checker (.*);

@@ test/command_frame_checker.sv @@
`timescale 1ns / 100ps

module command_frame_checker
    import cfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [2:0] i_result_code,
    input  logic [7:0] i_cmd_first,
    input  logic [7:0] i_cmd_second,
    input  logic [7:0] i_cmd_third,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_frame_bytes,
    output int         o_results_checked,
    output logic [7:0] o_codes_seen
);

    typedef struct packed {
        t_result    code;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } frame_result_t;

    // Shadow copy of the registers and the frame state
    logic [7:0]    start_val;
    logic [7:0]    end_val;
    logic [7:0]    max_len;
    logic          open_frame;
    logic [7:0]    frame_len;
    logic [7:0]    cmd_bytes [3];

    frame_result_t frame_results_due [$];
    int            fails;
    int            frame_bytes;
    int            results_checked;
    logic [7:0]    codes_seen;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    // Judge the kept command bytes: letters first, then the known upper-case codes
    function automatic t_result classify_command();
        if (!is_letter(cmd_bytes[0]) || !is_letter(cmd_bytes[1]) || !is_letter(cmd_bytes[2]))
            return RC_NONLETTER;
        if (cmd_bytes[0] != CH_R)
            return RC_UNKNOWN;
        case ({cmd_bytes[1], cmd_bytes[2]})
            {CH_T, CH_M}: return RC_RTM;
            {CH_F, CH_L}: return RC_RFL;
            {CH_I, CH_D}: return RC_RID;
            {CH_H, CH_L}: return RC_RHL;
            {CH_P, CH_R}: return RC_RPR;
            default:      return RC_UNKNOWN;
        endcase
    endfunction

    // Advance the frame by one byte; return 1 when the byte yields a result
    function automatic logic parse_byte(input logic [7:0] b, output t_result code);
        logic [8:0] next_len;
        code = RC_UNKNOWN;
        if (b == start_val) begin
            open_frame = 1'b1;
            frame_len  = '0;
        end
        if (!open_frame)
            return 1'b0;
        if (frame_len >= 8'd1 && frame_len <= 8'd3)
            cmd_bytes[frame_len - 8'd1] = b;
        // compare one bit wider so the count never wraps
        next_len = {1'b0, frame_len} + 9'd1;
        if (next_len > {1'b0, max_len}) begin
            open_frame = 1'b0;
            frame_len  = '0;
            code       = RC_TOOLONG;
            return 1'b1;
        end
        frame_len = next_len[7:0];
        if (b == end_val) begin
            open_frame = 1'b0;
            frame_len  = '0;
            code       = classify_command();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        frame_result_t seen;
        frame_result_t due;
        t_result       code;
        if (!i_rst_n) begin
            start_val  = START_BYTE_RST;
            end_val    = END_BYTE_RST;
            max_len    = MAX_LENGTH_RST;
            open_frame = 1'b0;
            frame_len  = '0;
            cmd_bytes  = '{default: '0};
            frame_results_due.delete();
        end else begin
            // Track register writes
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_START_BYTE: start_val = i_cfg_data;
                    CFG_END_BYTE:   end_val   = i_cfg_data;
                    CFG_MAX_LENGTH: max_len   = i_cfg_data;
                    default: ;
                endcase
            end
            // Check results before predicting, so a request on the same edge cannot
            // cover a stray result
            if (i_res_valid && i_res_ready) begin
                seen = frame_result_t'({i_result_code, i_cmd_first, i_cmd_second, i_cmd_third});
                codes_seen[i_result_code] = 1'b1;
                results_checked++;
                if (frame_results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result with none due: code %0d cmd %h %h %h", $time,
                                 seen.code, seen.first, seen.second, seen.third);
                end else begin
                    due = frame_results_due.pop_front();
                    if (seen !== due) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: expected code %0d cmd %h %h %h, got code %0d cmd %h %h %h",
                                     $time, due.code, due.first, due.second, due.third,
                                     seen.code, seen.first, seen.second, seen.third);
                    end
                end
            end
            // Predict from each accepted request
            if (i_rx_valid && i_rx_ready) begin
                if (open_frame || i_rx_byte == start_val)
                    frame_bytes++;
                if (parse_byte(i_rx_byte, code))
                    frame_results_due.push_back(
                        frame_result_t'({code, cmd_bytes[0], cmd_bytes[1], cmd_bytes[2]}));
            end
        end
        o_fail_count      <= fails;
        o_pending         <= frame_results_due.size();
        o_frame_bytes     <= frame_bytes;
        o_results_checked <= results_checked;
        o_codes_seen      <= codes_seen;
    end

    initial begin
        fails           = 0;
        frame_bytes     = 0;
        results_checked = 0;
        codes_seen      = '0;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cfp_pkg::*;

    localparam int PHASE_ITEMS    = 220;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       rx_valid;
    logic       rx_ready;
    logic [7:0] rx_byte;
    logic       res_valid;
    logic       res_ready;
    logic [2:0] result_code;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
    logic [7:0] cmd_third;

    int         fail_count;
    int         pending;
    int         frame_bytes;
    int         results_checked;
    logic [7:0] codes_seen;

    int         sender_idle_pct;
    int         recv_idle_pct;
    int         hold_req;
    int         hold_done;
    int         bytes_sent;
    int         stall_cycles;
    logic [7:0] cur_start;
    logic [7:0] cur_end;
    logic [7:0] cur_max;
    bit         long_done;

    logic [7:0] known_cmds [5][3] = '{'{CH_R, CH_T, CH_M}, '{CH_R, CH_F, CH_L},
                                      '{CH_R, CH_I, CH_D}, '{CH_R, CH_H, CH_L},
                                      '{CH_R, CH_P, CH_R}};

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    command_frame_parser_top u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_rx_valid   (rx_valid),
        .o_rx_ready   (rx_ready),
        .i_rx_byte    (rx_byte),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_result_code(result_code),
        .o_cmd_first  (cmd_first),
        .o_cmd_second (cmd_second),
        .o_cmd_third  (cmd_third)
    );

    command_frame_checker u_chk (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_rx_valid       (rx_valid),
        .i_rx_ready       (rx_ready),
        .i_rx_byte        (rx_byte),
        .i_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .i_result_code    (result_code),
        .i_cmd_first      (cmd_first),
        .i_cmd_second     (cmd_second),
        .i_cmd_third      (cmd_third),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_frame_bytes    (frame_bytes),
        .o_results_checked(results_checked),
        .o_codes_seen     (codes_seen)
    );

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        res_ready = 1'b0;
        hold_done = 0;
        forever begin
            @(negedge clk);
            if (hold_req != hold_done) begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done++;
            end
            res_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stop the run if no request moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (rx_valid && rx_ready) || (res_valid && res_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d results still due",
                     stall_cycles, pending);
            $display("** command_frame_parser_top: FAILED **");
            $finish;
        end
    end

    // A byte that neither opens nor closes a frame
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == cur_start || b == cur_end);
        return b;
    endfunction

    // Bytes at and around the letter ranges
    function automatic logic [7:0] near_letter();
        case ($urandom_range(0, 9))
            0:       return 8'h40;
            1:       return CH_UPPER_A;
            2:       return CH_UPPER_Z;
            3:       return 8'h5B;
            4:       return 8'h60;
            5:       return CH_LOWER_A;
            6:       return CH_LOWER_Z;
            7:       return 8'h7B;
            8:       return 8'($urandom_range(0, 255));
            default: return 8'(($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) +
                               $urandom_range(0, 25));
        endcase
    endfunction

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            rx_valid <= 1'b0;
            @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait for every due result, then let the block settle
    task automatic wait_idle();
        rx_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic apply_config(input logic [7:0] s, input logic [7:0] e, input logic [7:0] m);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_START_BYTE;
        cfg_data  <= s;
        @(negedge clk);
        cfg_index <= CFG_END_BYTE;
        cfg_data  <= e;
        @(negedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= m;
        @(negedge clk);
        // the spare index must be ignored
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 8'($urandom_range(0, 255));
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_start = s;
        cur_end   = e;
        cur_max   = m;
        @(negedge clk);
    endtask

    // One random frame: mostly well formed, some short, restarted, long or noise
    task automatic send_frame();
        int kind;
        int n;
        int k;
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, 4);
        if (kind < 40 || (kind >= 70 && kind < 78)) begin
            if (kind >= 70) begin
                // stray start and a few bytes ahead of the real frame
                send_byte(cur_start);
                repeat ($urandom_range(1, 3)) send_byte(plain_byte());
            end
            send_byte(cur_start);
            for (int i = 0; i < 3; i++)
                send_byte(($urandom_range(0, 99) < 12) ? near_letter() : known_cmds[k][i]);
            repeat ($urandom_range(0, 3)) send_byte(plain_byte());
            send_byte(cur_end);
        end else if (kind < 60) begin
            send_byte(cur_start);
            repeat (3) send_byte(near_letter());
            repeat ($urandom_range(0, 2)) send_byte(plain_byte());
            send_byte(cur_end);
        end else if (kind < 70) begin
            // short frame, judged on leftover command bytes
            send_byte(cur_start);
            repeat ($urandom_range(0, 2)) send_byte(near_letter());
            send_byte(cur_end);
        end else if (kind < 86 && (cur_max <= 8'd40 || !long_done)) begin
            // length right around the limit; only one such frame when the limit is large
            long_done = 1'b1;
            n = $urandom_range(0, 3);
            n = n + int'(cur_max) - 2;
            if (n < 0)
                n = 0;
            send_byte(cur_start);
            repeat (n) send_byte(plain_byte());
            send_byte(cur_end);
        end else begin
            // line noise, any value
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        string directed;
        int    target;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_START_BYTE;
        cfg_data        = '0;
        rx_valid        = 1'b0;
        rx_byte         = '0;
        hold_req        = 0;
        bytes_sent      = 0;
        stall_cycles    = 0;
        sender_idle_pct = 19;
        recv_idle_pct   = 53;
        cur_start       = START_BYTE_RST;
        cur_end         = END_BYTE_RST;
        cur_max         = MAX_LENGTH_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Every known command, then an empty frame that reads stale bytes
        directed = ":RTM;:RFL;:RID;:RHL;:RPR;:;";
        for (int i = 0; i < directed.len(); i++)
            send_byte(directed[i]);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1:       apply_config(8'h00, 8'hFF, 8'd4);
                    2:       apply_config(8'h3A, 8'h3A, 8'd254);
                    3:       apply_config(START_BYTE_RST, END_BYTE_RST, 8'd0);
                    4:       apply_config(8'($urandom_range(0, 255)),
                                          8'($urandom_range(0, 255)),
                                          8'($urandom_range(1, 24)));
                    default: apply_config(8'hFF, 8'h00, 8'd255);
                endcase
            end
            if (p < 2) begin
                sender_idle_pct = 19;
                recv_idle_pct   = 53;
            end else if (p < 4) begin
                sender_idle_pct = 53;
                recv_idle_pct   = 19;
            end else begin
                sender_idle_pct = 0;
                recv_idle_pct   = 0;
            end
            // hold off the receiver while frames keep coming
            if (p == 1 || p == 4)
                hold_req++;
            long_done = 1'b0;
            target    = bytes_sent + PHASE_ITEMS;
            while (bytes_sent < target)
                send_frame();
        end

        wait_idle();
        repeat (8) @(negedge clk);

        $display("Covered %0d bytes (%0d inside frames) over six register settings;",
                 bytes_sent, frame_bytes);
        $display("%0d results checked; result codes seen, RTM at bit 0: %b",
                 results_checked, codes_seen);
        if (fail_count == 0 && pending == 0)
            $display("** command_frame_parser_top: PASSED **");
        else
            $display("** command_frame_parser_top: FAILED **");
        $finish;
    end

endmodule
